// File: rtl/gdgt_pkg.sv
package gdgt_pkg;

    localparam int GDGT_MAX_NODES = 4096;
    localparam int NODE_W = 12;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_INV_STEP   = 2'd0;
    localparam logic [1:0] REG_VOLATILITY = 2'd1;
    localparam logic [1:0] REG_RATE       = 2'd2;

    localparam logic [31:0] INV_STEP_RESET   = 32'd65536;
    localparam logic [17:0] VOLATILITY_RESET = 18'd13107;
    localparam logic [17:0] RATE_RESET       = 18'd3277;

    typedef struct packed {
        logic signed [31:0] node_value;
        logic        [31:0] spot_price;
        logic               last_node;
    } in_word_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic signed [31:0] delta;
        logic signed [31:0] gamma;
        logic signed [31:0] theta;
        logic               final_result;
        logic               too_few_nodes;
    } out_word_t;

    // One result to be computed by the arithmetic side.
    typedef struct packed {
        logic [NODE_W-1:0]  idx;
        logic signed [34:0] ddiff;
        logic               half;
        logic signed [34:0] d2;
        logic signed [31:0] v;
        logic        [31:0] s;
        logic               fin;
        logic               few;
    } job_t;

endpackage

// File: rtl/gdgt_front.sv
module gdgt_front
    import gdgt_pkg::*;
#(
    parameter int MAX_NODES = GDGT_MAX_NODES
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    output logic     push,
    output job_t     push_job,
    input  logic     full
);

    localparam int CW = $clog2(MAX_NODES);

    logic signed [31:0] wv_reg [3];
    logic        [31:0] ws_reg [3];
    logic [CW-1:0]      count_reg;
    job_t               pend_reg [3];
    logic [1:0]         pend_cnt_reg;

    logic               accept;
    logic signed [34:0] nw0, nw1, nw2, d2;
    job_t               j_end0, j_mid, j_last, j_few;

    assign in_ready = (pend_cnt_reg == 2'd0);
    assign accept   = in_valid && in_ready;
    assign push     = (pend_cnt_reg != 2'd0) && !full;
    assign push_job = pend_reg[0];

    always_comb
    begin
        nw0 = {{3{wv_reg[1][31]}}, wv_reg[1]};
        nw1 = {{3{wv_reg[2][31]}}, wv_reg[2]};
        nw2 = {{3{in_word.node_value[31]}}, in_word.node_value};
        d2  = nw2 - (nw1 <<< 1) + nw0;

        j_end0 = '{idx: '0, ddiff: nw1 - nw0, half: 1'b0, d2: d2, v: wv_reg[1],
                   s: ws_reg[1], fin: 1'b0, few: 1'b0};
        j_mid  = '{idx: NODE_W'(count_reg - CW'(1)), ddiff: nw2 - nw0, half: 1'b1,
                   d2: d2, v: wv_reg[2], s: ws_reg[2], fin: 1'b0, few: 1'b0};
        j_last = '{idx: NODE_W'(count_reg), ddiff: nw2 - nw1, half: 1'b0, d2: d2,
                   v: in_word.node_value, s: in_word.spot_price, fin: 1'b1, few: 1'b0};
        j_few  = '{idx: NODE_W'(count_reg), ddiff: '0, half: 1'b0, d2: '0, v: '0,
                   s: '0, fin: 1'b1, few: 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pend_cnt_reg <= 2'd0;
            for (int i = 0; i < 3; i++)
            begin
                wv_reg[i] <= '0;
                ws_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            wv_reg[0] <= wv_reg[1];
            wv_reg[1] <= wv_reg[2];
            wv_reg[2] <= in_word.node_value;
            ws_reg[0] <= ws_reg[1];
            ws_reg[1] <= ws_reg[2];
            ws_reg[2] <= in_word.spot_price;
            if (count_reg < CW'(2))
            begin
                if (in_word.last_node)
                begin
                    pend_reg[0]  <= j_few;
                    pend_cnt_reg <= 2'd1;
                    count_reg    <= '0;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            else
            begin
                if (count_reg == CW'(2))
                begin
                    pend_reg[0]  <= j_end0;
                    pend_reg[1]  <= j_mid;
                    pend_reg[2]  <= j_last;
                    pend_cnt_reg <= in_word.last_node ? 2'd3 : 2'd2;
                end
                else
                begin
                    pend_reg[0]  <= j_mid;
                    pend_reg[1]  <= j_last;
                    pend_cnt_reg <= in_word.last_node ? 2'd2 : 2'd1;
                end
                if (in_word.last_node)
                begin
                    count_reg <= '0;
                end
                else if (count_reg < CW'(MAX_NODES - 1))
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
        else if (push)
        begin
            pend_reg[0]  <= pend_reg[1];
            pend_reg[1]  <= pend_reg[2];
            pend_cnt_reg <= pend_cnt_reg - 2'd1;
        end
    end

endmodule

// File: rtl/gdgt_queue.sv
module gdgt_queue
    import gdgt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic pop_valid,
    output job_t pop_job,
    input  logic pop
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full      = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop && pop_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && pop_valid);
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> cnt_reg == $past(cnt_reg) + (QPTR_W+1)'(1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_valid && !push) |=> cnt_reg == $past(cnt_reg) - (QPTR_W+1)'(1))
        else $error("queue count did not shrink on pop");

endmodule

// File: rtl/gdgt_back.sv
module gdgt_back
    import gdgt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_pop,
    input  logic        [31:0] inv_step,
    input  logic        [17:0] volatility,
    input  logic signed [17:0] rate,
    output logic               out_valid,
    input  logic               out_ready,
    output out_word_t          out_word
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SAT  = 4'b0100,
        ST_PUT  = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        OP_G1, OP_GAMMA, OP_DELTA, OP_HS2, OP_P1, OP_P2, OP_T1, OP_Q1, OP_T2, OP_T3
    } op_t;

    state_t             state_reg;
    op_t                op_reg;
    job_t               job_reg;
    logic signed [34:0] chain_reg;
    logic signed [31:0] gamma_reg, delta_reg;
    logic signed [33:0] acc_reg;
    logic        [67:0] prod_reg;
    logic               neg_reg, half_reg;
    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic signed [34:0] opa, opb, res_ext;
    logic        [33:0] ma, mb;
    logic               sh;
    logic        [67:0] q;
    logic signed [31:0] res, theta_sat;
    logic               load_out;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign job_pop   = (state_reg == ST_IDLE) && job_valid;
    assign load_out  = (state_reg == ST_PUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        opa = '0;
        opb = '0;
        sh  = 1'b0;
        unique case (op_reg)
            OP_G1:    begin opa = job_reg.d2;    opb = {3'b000, inv_step}; end
            OP_GAMMA: begin opa = chain_reg;     opb = {3'b000, inv_step}; end
            OP_DELTA:
            begin
                opa = job_reg.ddiff;
                opb = {3'b000, inv_step};
                sh  = job_reg.half;
            end
            OP_HS2:
            begin
                opa = {17'd0, volatility};
                opb = {17'd0, volatility};
                sh  = 1'b1;
            end
            OP_P1, OP_P2:
            begin
                opa = chain_reg;
                opb = {3'b000, job_reg.s};
            end
            OP_T1:    begin opa = chain_reg; opb = {{3{gamma_reg[31]}}, gamma_reg}; end
            OP_Q1:    begin opa = {{17{rate[17]}}, rate}; opb = {3'b000, job_reg.s}; end
            OP_T2:    begin opa = chain_reg; opb = {{3{delta_reg[31]}}, delta_reg}; end
            OP_T3:
            begin
                opa = {{17{rate[17]}}, rate};
                opb = {{3{job_reg.v[31]}}, job_reg.v};
            end
            default:  begin opa = '0; opb = '0; end
        endcase
        ma = opa[34] ? 34'(-opa) : opa[33:0];
        mb = opb[34] ? 34'(-opb) : opb[33:0];

        // Scale back, truncating toward zero, then saturate to 32 bits.
        q = half_reg ? (prod_reg >> 17) : (prod_reg >> 16);
        if (neg_reg)
        begin
            res = (q > 68'h80000000) ? 32'sh80000000 : 32'(-q[31:0]);
        end
        else
        begin
            res = (q > 68'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
        end
        res_ext = {{3{res[31]}}, res};

        if (acc_reg > 34'sh07FFFFFFF)
        begin
            theta_sat = 32'sh7FFFFFFF;
        end
        else if (acc_reg < -34'sh080000000)
        begin
            theta_sat = 32'sh80000000;
        end
        else
        begin
            theta_sat = acc_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg   <= job;
                gamma_reg <= '0;
                delta_reg <= '0;
                acc_reg   <= '0;
            end
            ST_MUL:
            begin
                prod_reg <= ma * mb;
                neg_reg  <= opa[34] ^ opb[34];
                half_reg <= sh;
            end
            ST_SAT:
            begin
                unique case (op_reg)
                    OP_GAMMA: gamma_reg <= res;
                    OP_DELTA: delta_reg <= res;
                    OP_T1:    acc_reg   <= -{{2{res[31]}}, res};
                    OP_T2:    acc_reg   <= acc_reg - {{2{res[31]}}, res};
                    OP_T3:    acc_reg   <= acc_reg + {{2{res[31]}}, res};
                    default:  chain_reg <= res_ext;
                endcase
            end
            ST_PUT:
            begin
                if (load_out)
                begin
                    out_word_reg <= '{node_index: job_reg.idx, delta: delta_reg,
                                      gamma: gamma_reg, theta: theta_sat,
                                      final_result: job_reg.fin,
                                      too_few_nodes: job_reg.few};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_G1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    op_reg <= OP_G1;
                    if (job_valid)
                    begin
                        state_reg <= job.few ? ST_PUT : ST_MUL;
                    end
                end
                ST_MUL:  state_reg <= ST_SAT;
                ST_SAT:
                begin
                    if (op_reg == OP_T3)
                    begin
                        state_reg <= ST_PUT;
                    end
                    else
                    begin
                        op_reg    <= op_t'(op_reg + 4'd1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_PUT:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/grid_delta_gamma_theta_unit.sv
// Streaming finite-difference Greeks for one solved pricing grid.
// Input words carry the option value and spot price of one grid node, in node
// order, with last_node set on the final node. Output words carry a node's index
// and its delta, gamma and theta, all three signed Q16.16 and saturated.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Results trail the input by one node: node 0 and node 1 come out after node 2
// is taken, and the last node also flushes its own result. A grid that ends
// before three nodes yields a single word with too_few_nodes set.
// Each result other than a too_few_nodes word is computed by one shared
// magnitude multiplier that takes ten products in turn, each through the MUL
// and SAT states. A four-entry job queue lets the input side take the next
// word while the arithmetic side works.
// When the receiver stalls, the finished word waits in the output register,
// the arithmetic side stops, the queue fills and in_ready then drops.
// Reset clears the node window and counter and loads the register defaults;
// the user must write the plain configuration port only while idle, unenforced.
module grid_delta_gamma_theta_unit
    import gdgt_pkg::*;
#(
    parameter int MAX_NODES = GDGT_MAX_NODES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_word,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic        [31:0] inv_step_reg;
    logic        [17:0] volatility_reg;
    logic signed [17:0] rate_reg;

    logic push, full, job_valid, job_pop;
    job_t push_job, job;

    // Configuration registers; a write to an index outside the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_step_reg   <= INV_STEP_RESET;
            volatility_reg <= VOLATILITY_RESET;
            rate_reg       <= RATE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INV_STEP:   inv_step_reg   <= cfg_data;
                REG_VOLATILITY: volatility_reg <= cfg_data[17:0];
                REG_RATE:       rate_reg       <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // The front keeps the three-node window and turns each node into jobs.
    gdgt_front #(
        .MAX_NODES(MAX_NODES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    gdgt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop_valid (job_valid),
        .pop_job   (job),
        .pop       (job_pop)
    );

    // The back runs the multiply sequence and owns the output register.
    gdgt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job),
        .job_pop    (job_pop),
        .inv_step   (inv_step_reg),
        .volatility (volatility_reg),
        .rate       (rate_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

endmodule
